[src/chi_pkg.sv]
// shared types, constants and helpers for the cubic hermite interpolator
// no dependencies
package chi_pkg;

    localparam int FracBitsDef = 16;
    localparam int WordW       = 32;
    localparam int IdxW        = 3;
    localparam int DivSteps    = 64;

    localparam logic [IdxW-1:0] REG_X0 = 3'd0;
    localparam logic [IdxW-1:0] REG_F0 = 3'd1;
    localparam logic [IdxW-1:0] REG_D0 = 3'd2;
    localparam logic [IdxW-1:0] REG_X1 = 3'd3;
    localparam logic [IdxW-1:0] REG_F1 = 3'd4;
    localparam logic [IdxW-1:0] REG_D1 = 3'd5;

    localparam logic [1:0] COEF_S  = 2'd0;
    localparam logic [1:0] COEF_Q2 = 2'd1;
    localparam logic [1:0] COEF_T  = 2'd2;
    localparam logic [1:0] COEF_Q3 = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ITER,
        ST_STORE
    } t_state;

    typedef struct packed {
        logic              ovf;
        logic signed [31:0] val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end else begin
            r.ovf = 1'b1;
            r.val = v[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return r;
    endfunction

endpackage

[src/cubic_hermite_interpolator.sv]
// Usage notes for the cubic hermite interpolator.
// Slave stream: i_s_axis_tdata carries one query point (signed fixed point).
// Master stream: o_m_axis_tdata carries the interpolated value, o_m_axis_tuser
// carries the degenerate flag (bit 0) and the overflow flag (bit 1).
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx; indexes
// 0..5 are x0, f0, d0, x1, f1, d1, any other index is ignored.
// After every config write the coefficient sequencer recomputes the four
// divided differences with a shared radix-2 divider, and o_s_axis_tready
// is low while it runs. Coefficients at reset are zero, so no recompute
// runs after reset.
// The pipeline has seven register stages, r1 to r7; o_m_axis_tvalid is the
// valid bit of the last one. Throughput: one query per cycle while the
// receiver is ready and no coefficient recompute runs, set by the seven
// stage multiply pipeline (one multiplier level per stage pair).
// Reset (synchronous, active low) empties the pipeline and loads the
// default nodes x0 = 0, x1 = 1.0.
// When the receiver stalls the whole pipeline holds and o_s_axis_tready
// drops; nothing is lost or repeated.
// Depends on chi_pkg.
module cubic_hermite_interpolator #(
    parameter int FRAC_BITS = chi_pkg::FracBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // query_point
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // interp_value
    output logic [1:0]  o_m_axis_tuser    // degenerate, overflow
);

    // configuration
    logic signed [31:0] r_x0, r_f0, r_d0, r_x1, r_f1, r_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0 <= '0;
            r_f0 <= '0;
            r_d0 <= '0;
            r_x1 <= 32'sd65536;
            r_f1 <= '0;
            r_d1 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                chi_pkg::REG_X0: r_x0 <= i_cfg_data;
                chi_pkg::REG_F0: r_f0 <= i_cfg_data;
                chi_pkg::REG_D0: r_d0 <= i_cfg_data;
                chi_pkg::REG_X1: r_x1 <= i_cfg_data;
                chi_pkg::REG_F1: r_f1 <= i_cfg_data;
                chi_pkg::REG_D1: r_d1 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient sequencer and divider
    chi_pkg::t_state r_state, n_state;
    logic [1:0]  r_sel;
    logic [5:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [32:0] r_rem;
    logic        r_neg;
    logic signed [31:0] r_s, r_q2, r_t, r_q3;
    logic        r_covf;

    logic signed [32:0] h;
    logic [32:0]        h_mag;
    logic signed [32:0] num;
    logic [32:0]        num_mag;
    logic [33:0]        rem_sh;
    logic               qbit;
    logic [33:0]        rem_sub;
    logic signed [63:0] quo_s;
    chi_pkg::t_sat      coef_sat;
    logic               busy;

    assign h     = 33'(r_x1) - 33'(r_x0);
    assign h_mag = h[32] ? 33'(-h) : 33'(h);

    always_comb begin
        case (r_sel)
            chi_pkg::COEF_S:  num = 33'(r_f1) - 33'(r_f0);
            chi_pkg::COEF_Q2: num = 33'(r_s) - 33'(r_d0);
            chi_pkg::COEF_T:  num = 33'(r_d1) - 33'(r_s);
            default:          num = 33'(r_t) - 33'(r_q2);
        endcase
    end

    assign num_mag  = num[32] ? 33'(-num) : 33'(num);
    assign rem_sh   = {r_rem, r_dvd[63]};
    assign qbit     = rem_sh >= {1'b0, h_mag};
    assign rem_sub  = qbit ? rem_sh - {1'b0, h_mag} : rem_sh;
    assign quo_s    = r_neg ? -$signed(r_dvd) : $signed(r_dvd);
    assign coef_sat = chi_pkg::sat32(quo_s);

    always_comb begin
        n_state = r_state;
        case (r_state)
            chi_pkg::ST_IDLE:  n_state = chi_pkg::ST_IDLE;
            chi_pkg::ST_LOAD:  n_state = chi_pkg::ST_ITER;
            chi_pkg::ST_ITER:  if (r_cnt == 6'(chi_pkg::DivSteps - 1)) begin
                n_state = chi_pkg::ST_STORE;
            end
            chi_pkg::ST_STORE: n_state = (r_sel == chi_pkg::COEF_Q3) ?
                                         chi_pkg::ST_IDLE : chi_pkg::ST_LOAD;
            default:           n_state = chi_pkg::ST_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = chi_pkg::ST_LOAD;
        end
    end

    always_comb begin
        case (r_state)
            chi_pkg::ST_IDLE: busy = 1'b0;
            default:          busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chi_pkg::ST_IDLE;
            r_sel   <= '0;
            r_cnt   <= '0;
            r_covf  <= 1'b0;
            r_s     <= '0;
            r_q2    <= '0;
            r_t     <= '0;
            r_q3    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_sel  <= chi_pkg::COEF_S;
                r_covf <= 1'b0;
            end else begin
                case (r_state)
                    chi_pkg::ST_LOAD: r_cnt <= '0;
                    chi_pkg::ST_ITER: r_cnt <= r_cnt + 6'd1;
                    chi_pkg::ST_STORE: begin
                        r_covf <= r_covf | coef_sat.ovf;
                        case (r_sel)
                            chi_pkg::COEF_S:  r_s  <= coef_sat.val;
                            chi_pkg::COEF_Q2: r_q2 <= coef_sat.val;
                            chi_pkg::COEF_T:  r_t  <= coef_sat.val;
                            default:          r_q3 <= coef_sat.val;
                        endcase
                        r_sel <= r_sel + 2'd1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            chi_pkg::ST_LOAD: begin
                r_dvd <= 64'(num_mag) << FRAC_BITS;
                r_rem <= '0;
                r_neg <= num[32] ^ h[32];
            end
            chi_pkg::ST_ITER: begin
                r_dvd <= {r_dvd[62:0], qbit};
                r_rem <= rem_sub[32:0];
            end
            default: ;
        endcase
    end

    // evaluation pipeline
    logic en, acc;
    logic r1_vl, r2_vl, r3_vl, r4_vl, r5_vl, r6_vl, r7_vl;
    logic r1_deg, r2_deg, r3_deg, r4_deg, r5_deg, r6_deg;
    logic r1_ovf, r2_ovf, r3_ovf, r4_ovf, r5_ovf, r6_ovf;
    logic signed [31:0] r1_u, r1_dv, r2_dv, r3_dv, r3_p1, r3_u2, r4_p1, r5_w;
    logic signed [63:0] r2_p1, r2_u2, r4_p2, r4_w, r6_p3;
    logic signed [33:0] r5_acc, r6_acc;
    logic signed [31:0] r7_val;
    logic               r7_deg, r7_ovf;

    chi_pkg::t_sat s_u, s_v, s_p1, s_u2, s_p2, s_w, s_p3, s_sum;

    assign en  = !r7_vl || i_m_axis_tready;
    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    assign s_u   = chi_pkg::sat32(64'($signed(i_s_axis_tdata)) - 64'(r_x0));
    assign s_v   = chi_pkg::sat32(64'($signed(i_s_axis_tdata)) - 64'(r_x1));
    assign s_p1  = chi_pkg::sat32(r2_p1 >>> FRAC_BITS);
    assign s_u2  = chi_pkg::sat32(r2_u2 >>> FRAC_BITS);
    assign s_p2  = chi_pkg::sat32(r4_p2 >>> FRAC_BITS);
    assign s_w   = chi_pkg::sat32(r4_w >>> FRAC_BITS);
    assign s_p3  = chi_pkg::sat32(r6_p3 >>> FRAC_BITS);
    assign s_sum = chi_pkg::sat32(64'(r6_acc) + 64'(s_p3.val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vl <= 1'b0;
            r2_vl <= 1'b0;
            r3_vl <= 1'b0;
            r4_vl <= 1'b0;
            r5_vl <= 1'b0;
            r6_vl <= 1'b0;
            r7_vl <= 1'b0;
        end else if (en) begin
            r1_vl <= acc;
            r2_vl <= r1_vl;
            r3_vl <= r2_vl;
            r4_vl <= r3_vl;
            r5_vl <= r4_vl;
            r6_vl <= r5_vl;
            r7_vl <= r6_vl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_u   <= s_u.val;
            r1_dv  <= s_v.val;
            r1_ovf <= s_u.ovf | s_v.ovf | r_covf;
            r1_deg <= (h == '0);

            r2_p1  <= 64'(r_d0) * 64'(r1_u);
            r2_u2  <= 64'(r1_u) * 64'(r1_u);
            r2_dv  <= r1_dv;
            r2_ovf <= r1_ovf;
            r2_deg <= r1_deg;

            r3_p1  <= s_p1.val;
            r3_u2  <= s_u2.val;
            r3_dv  <= r2_dv;
            r3_ovf <= r2_ovf | s_p1.ovf | s_u2.ovf;
            r3_deg <= r2_deg;

            r4_p2  <= 64'(r_q2) * 64'(r3_u2);
            r4_w   <= 64'(r3_u2) * 64'(r3_dv);
            r4_p1  <= r3_p1;
            r4_ovf <= r3_ovf;
            r4_deg <= r3_deg;

            r5_w   <= s_w.val;
            r5_acc <= 34'(r_f0) + 34'(r4_p1) + 34'(s_p2.val);
            r5_ovf <= r4_ovf | s_p2.ovf | s_w.ovf;
            r5_deg <= r4_deg;

            r6_p3  <= 64'(r_q3) * 64'(r5_w);
            r6_acc <= r5_acc;
            r6_ovf <= r5_ovf;
            r6_deg <= r5_deg;

            r7_val <= r6_deg ? '0 : s_sum.val;
            r7_ovf <= !r6_deg && (r6_ovf | s_p3.ovf | s_sum.ovf);
            r7_deg <= r6_deg;
        end
    end

    assign o_s_axis_tready = en && !busy;
    assign o_m_axis_tvalid = r7_vl;
    assign o_m_axis_tdata  = r7_val;
    assign o_m_axis_tuser  = {r7_ovf, r7_deg};

endmodule

[src/chi_checker.sv]
// port level checks for the cubic hermite interpolator
// bound to cubic_hermite_interpolator; no package dependency
module chi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while output stalled");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_axis_tready)
        else $error("input taken during coefficient update");

    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |->
            (!o_m_axis_tuser[1] && o_m_axis_tdata == 32'd0))
        else $error("degenerate result not cleared");

endmodule

bind cubic_hermite_interpolator chi_checker u_chi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_cfg_we       (i_cfg_we),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);

[tb/cubic_hermite_interpolator_test.sv]
// testbench for the cubic hermite interpolator: query points streamed under several node sets
// predicts each interpolated value and its flags and compares every result transaction
// depends on chi_pkg and cubic_hermite_interpolator
`timescale 1ns / 100ps

module cubic_hermite_interpolator_test;

    localparam int FB = chi_pkg::FracBitsDef;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    typedef struct {
        logic [31:0] value;
        logic        degen;
        logic        ovf;
    } t_interp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;    // query_point
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;         // interp_value
    logic [1:0]  o_m_axis_tuser;         // degenerate, overflow

    cubic_hermite_interpolator #(.FRAC_BITS(FB)) uut (.*);

    always #10 i_clk = ~i_clk;

    // node registers as the block should hold them
    longint nodes [6] = '{0, 0, 0, 65536, 0, 0};
    logic [31:0] queries [$];
    t_interp     interp_expected [$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    bit          query_taken = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;

    function automatic longint clip32(longint v, ref bit ovf);
        if (v > WMAX) begin ovf = 1'b1; return WMAX; end
        if (v < WMIN) begin ovf = 1'b1; return WMIN; end
        return v;
    endfunction

    function automatic longint qdiv(longint num, longint h, ref bit ovf);
        return clip32((num <<< FB) / h, ovf);
    endfunction

    function automatic longint qmul(longint a, longint b, ref bit ovf);
        return clip32((a * b) >>> FB, ovf);
    endfunction

    function automatic t_interp hermite_eval(logic [31:0] q);
        t_interp r;
        bit ovf = 1'b0;
        longint x, h, s, t, q2, q3, u, v, p1, u2, p2, w, p3;
        x = longint'($signed(q));
        h = nodes[chi_pkg::REG_X1] - nodes[chi_pkg::REG_X0];
        if (h == 0) begin
            r.value = '0; r.degen = 1'b1; r.ovf = 1'b0;
            return r;
        end
        s  = qdiv(nodes[chi_pkg::REG_F1] - nodes[chi_pkg::REG_F0], h, ovf);
        q2 = qdiv(s - nodes[chi_pkg::REG_D0], h, ovf);
        t  = qdiv(nodes[chi_pkg::REG_D1] - s, h, ovf);
        q3 = qdiv(t - q2, h, ovf);
        u  = clip32(x - nodes[chi_pkg::REG_X0], ovf);
        v  = clip32(x - nodes[chi_pkg::REG_X1], ovf);
        p1 = qmul(nodes[chi_pkg::REG_D0], u, ovf);
        u2 = qmul(u, u, ovf);
        p2 = qmul(q2, u2, ovf);
        w  = qmul(u2, v, ovf);
        p3 = qmul(q3, w, ovf);
        r.value = 32'(clip32(nodes[chi_pkg::REG_F0] + p1 + p2 + p3, ovf));
        r.degen = 1'b0;
        r.ovf = ovf;
        return r;
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_axis_tvalid || query_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (queries.size() > 0) begin
                i_s_axis_tdata <= queries[0];
                interp_expected.push_back(hermite_eval(queries[0]));
                void'(queries.pop_front());
                i_s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 18);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_interp e;
        query_taken <= i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (interp_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %h", o_m_axis_tdata);
            end else begin
                e = interp_expected.pop_front();
                if (o_m_axis_tdata !== e.value || o_m_axis_tuser[0] !== e.degen ||
                    o_m_axis_tuser[1] !== e.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h deg %b ovf %b, got %h deg %b ovf %b",
                                 e.value, e.degen, e.ovf, o_m_axis_tdata,
                                 o_m_axis_tuser[0], o_m_axis_tuser[1]);
                end
            end
        end
    end

    task automatic write_reg(int idx, longint data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= 3'(idx);
        i_cfg_data <= 32'(data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < 6) nodes[idx] = longint'($signed(32'(data)));
        repeat (2) @(negedge i_clk);
        while (!o_s_axis_tready) @(negedge i_clk);
    endtask

    task automatic drain;
        wait (queries.size() == 0 && interp_expected.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic longint srand(longint span);
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    task automatic set_nodes(longint x0, longint f0, longint d0,
                             longint x1, longint f1, longint d1);
        write_reg(chi_pkg::REG_X0, x0); write_reg(chi_pkg::REG_F0, f0);
        write_reg(chi_pkg::REG_D0, d0); write_reg(chi_pkg::REG_X1, x1);
        write_reg(chi_pkg::REG_F1, f1); write_reg(chi_pkg::REG_D1, d1);
    endtask

    task automatic queue_queries(int n);
        longint lo, span, q;
        lo = nodes[chi_pkg::REG_X0];
        span = nodes[chi_pkg::REG_X1] - nodes[chi_pkg::REG_X0];
        if (span < 0) begin lo = nodes[chi_pkg::REG_X1]; span = -span; end
        if (span > 32'h3fff_ffff) span = 32'h3fff_ffff;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 80) begin
                q = lo + longint'($urandom_range(0, 32'(3 * span + 2))) - span - 1;
                if (q > WMAX) q = WMAX;
                if (q < WMIN) q = WMIN;
                queries.push_back(32'(q));
            end else begin
                queries.push_back($urandom);
            end
        end
    endtask

    initial begin
        longint x0, h;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default nodes give a flat zero curve
        queries = '{32'h0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000,
                    32'hffff_ffff, 32'h0000_8000, 32'h0002_0000};
        drain();

        // unknown register indexes are ignored
        write_reg(6, 32'h1234_5678);
        write_reg(7, 32'hffff_ffff);
        set_nodes(0, 65536, 65536, 65536, 131072, -65536);
        queries = '{32'h0, 32'h0000_8000, 32'h0001_0000, 32'hfffe_0000, 32'h0100_0000};
        drain();

        // coincident nodes
        set_nodes(32'h0003_0000, 12345, 777, 32'h0003_0000, -5, 3);
        queries = '{32'h0, 32'h0003_0000, 32'h7fff_ffff, 32'h8000_0000};
        drain();

        // extremes
        set_nodes(WMIN, WMAX, WMAX, WMAX, WMIN, WMIN);
        queries = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        drain();
        set_nodes(WMAX, WMIN, WMIN, WMIN, WMAX, WMAX);
        queries = '{32'h8000_0000, 32'h7fff_ffff, 32'h0};
        drain();
        set_nodes(0, WMAX, 0, 1, WMIN, 0);
        queries = '{32'h0, 32'h1, 32'h2};
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 8) calm = 1'b1;
            if (ph % 4 == 3) begin
                set_nodes(longint'($signed($urandom)), longint'($signed($urandom)),
                          longint'($signed($urandom)), longint'($signed($urandom)),
                          longint'($signed($urandom)), longint'($signed($urandom)));
            end else begin
                x0 = srand(32'h0008_0000);
                h = longint'($urandom_range(1, 32'h0004_0000));
                if ($urandom_range(0, 1)) h = -h;
                set_nodes(x0, srand(32'h0010_0000), srand(32'h0010_0000),
                          x0 + h, srand(32'h0010_0000), srand(32'h0010_0000));
            end
            queue_queries(100);
            drain();
        end

        if (mismatches == 0 && interp_expected.size() == 0) begin
            $display("cubic_hermite_interpolator test passed");
        end else begin
            $display("cubic_hermite_interpolator test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("cubic_hermite_interpolator test failed");
        $finish;
    end

endmodule
